/* sv/owsbe_pkg.sv */
package owsbe_pkg;

    // command codes, also used for the finished kind
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_RESET  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_MATCH  = 3'd4;
    localparam logic [2:0] OP_SEARCH = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_SAMPLE  = 3'd0;
    localparam logic [2:0] REG_TAIL    = 3'd1;
    localparam logic [2:0] REG_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_ONE     = 3'd3;
    localparam logic [2:0] REG_ZLOW    = 3'd4;
    localparam logic [2:0] REG_ZREL    = 3'd5;
    localparam logic [2:0] REG_MINP    = 3'd6;
    localparam logic [2:0] REG_MAXP    = 3'd7;

    localparam int NUM_REGS = 8;

    localparam logic [7:0] POLL_TICKS = 8'd10;

    typedef logic [7:0] t_cfg_array [NUM_REGS];

    localparam t_cfg_array CFG_RESET = '{8'd10, 8'd35, 8'd41, 8'd55,
                                         8'd17, 8'd35, 8'd10, 8'd50};

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST       = 4'd1,
        PH_RD_SAMPLE = 4'd2,
        PH_RD_TAIL   = 4'd3,
        PH_RD_HOLD   = 4'd4,
        PH_WR_ONE    = 4'd5,
        PH_WR_LOW    = 4'd6,
        PH_WR_REL    = 4'd7,
        PH_WAIT_LOW  = 4'd8
    } t_phase;

    typedef struct packed {
        logic       busy_res;
        logic       error;
        logic       matched;
        logic [7:0] read_value;
        logic       reset_seen;
        logic [2:0] finished_kind;
        logic       done_res;
        logic       drive_low;
    } t_result;

endpackage

/* sv/onewire_slave_bit_engine.sv */
// 1-Wire slave bit engine.
// Input stream: one item per bus microsecond. tuser carries the op (tick, reset
// check, read byte, write byte, match bit, search bit); tdata carries the sampled
// line level and the data byte. A command op (reset to search) starts a command only while
// idle; otherwise, and for tick or an undefined op, the item is just a tick.
// Output stream: exactly one result item per input item: drive_low for this tick,
// done flag and finished kind, reset_seen, read byte, match flag, sticky error and
// busy.
// Configuration: eight 8-bit timing registers, written through i_cfg_we /
// i_cfg_index / i_cfg_data by the user only while the engine is idle; not enforced.
// The result is registered. Throughput: one item per cycle while the output buffer
// has room; the slot state is updated by short combinational logic from the state
// registers to the result register.
// A two-entry output buffer (result register plus skid register) lets the engine
// take another item while one result waits; if the receiver keeps tready low, the
// slave tready drops once both entries are full and no state advances.
// Reset (synchronous, active low): engine idle, counters and sticky error cleared,
// registers back to their defaults, output buffer empty.
module onewire_slave_bit_engine
    import owsbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [0] line, [8:1] data, [15:9] zero
    input  logic [2:0]  i_s_tuser,   // [2:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [0] drive_low, [1] done_res, [2] reset_seen,
                                     // [10:3] read_value, [11] matched, [12] error,
                                     // [13] busy_res, [15:14] zero
    output logic [2:0]  o_m_tuser,   // [2:0] finished_kind
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg_array r_cfg;

    t_phase     r_phase, n_phase;
    logic [2:0] r_cmd, n_cmd;
    logic [7:0] r_tick, n_tick;
    logic [7:0] r_poll, n_poll;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic       r_sampled, n_sampled;
    logic       r_sticky, n_sticky;

    t_result    n_res;
    t_result    r_m_data, r_sk_data;
    logic       r_m_valid, r_sk_valid;

    logic       s_acc, m_acc;
    logic [2:0] in_op;
    logic       in_line;
    logic [7:0] in_data;

    logic       rd_end, rd_bit, rd_to, wr_end, fin;
    logic [7:0] tick_inc, poll_inc;
    logic [7:0] shift_start;

    // phase of a new slot
    function automatic t_phase slot_phase(input logic [2:0] cmd, input logic [2:0] idx,
                                          input logic [7:0] shift);
        logic w;
        if (cmd == OP_READ || cmd == OP_MATCH || (cmd == OP_SEARCH && idx >= 3'd2)) begin
            return PH_RD_SAMPLE;
        end
        if (cmd == OP_WRITE) begin
            w = shift[idx];
        end else begin
            w = shift[0] ^ (idx != 3'd0);
        end
        return w ? PH_WR_ONE : PH_WR_LOW;
    endfunction

    assign in_op   = i_s_tuser;
    assign in_line = i_s_tdata[0];
    assign in_data = i_s_tdata[8:1];

    assign o_s_tready = !r_sk_valid;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = r_m_valid && i_m_tready;

    assign tick_inc = r_tick + 8'd1;
    assign poll_inc = r_poll + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_tick    = r_tick;
        n_poll    = r_poll;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_sampled = r_sampled;
        n_sticky  = r_sticky;
        n_res     = '0;
        rd_end    = 1'b0;
        rd_bit    = 1'b0;
        rd_to     = 1'b0;
        wr_end    = 1'b0;
        fin       = 1'b0;
        shift_start = 8'd0;

        if (r_phase != PH_IDLE) begin
            unique case (r_phase)
                PH_RST: begin
                    n_tick = tick_inc;
                    if (tick_inc >= POLL_TICKS) begin
                        n_tick = 8'd0;
                        if (!in_line) begin
                            n_poll = poll_inc;
                        end
                        if (in_line || poll_inc >= r_cfg[REG_MAXP]) begin
                            n_res.reset_seen = (n_poll >= r_cfg[REG_MINP]);
                            fin = 1'b1;
                        end
                    end
                end
                PH_RD_SAMPLE: begin
                    n_tick = tick_inc;
                    if (tick_inc >= r_cfg[REG_SAMPLE]) begin
                        n_sampled = in_line;
                        n_tick    = 8'd0;
                        if (r_cmd == OP_SEARCH && in_line != r_shift[0]) begin
                            fin = 1'b1;
                        end else begin
                            n_phase = PH_RD_TAIL;
                        end
                    end
                end
                PH_RD_TAIL: begin
                    n_tick = tick_inc;
                    if (tick_inc >= r_cfg[REG_TAIL]) begin
                        n_tick = 8'd0;
                        if (in_line) begin
                            rd_end = 1'b1;
                            rd_bit = r_sampled;
                        end else begin
                            n_phase = PH_RD_HOLD;
                        end
                    end
                end
                PH_RD_HOLD: begin
                    if (in_line) begin
                        rd_end = 1'b1;
                        rd_bit = r_sampled;
                    end else begin
                        n_tick = tick_inc;
                        if (tick_inc >= r_cfg[REG_TIMEOUT]) begin
                            n_sticky = 1'b1;
                            rd_end   = 1'b1;
                            rd_to    = 1'b1;
                        end
                    end
                end
                PH_WR_ONE: begin
                    n_tick = tick_inc;
                    wr_end = (tick_inc >= r_cfg[REG_ONE]);
                end
                PH_WR_LOW: begin
                    n_res.drive_low = 1'b1;
                    n_tick = tick_inc;
                    if (tick_inc >= r_cfg[REG_ZLOW]) begin
                        n_tick = 8'd0;
                        if (r_cfg[REG_ZREL] == 8'd0) begin
                            wr_end = 1'b1;
                        end else begin
                            n_phase = PH_WR_REL;
                        end
                    end
                end
                PH_WR_REL: begin
                    n_tick = tick_inc;
                    wr_end = (tick_inc >= r_cfg[REG_ZREL]);
                end
                PH_WAIT_LOW: begin
                    if (!in_line) begin
                        n_tick  = 8'd0;
                        n_phase = slot_phase(r_cmd, r_bit, r_shift);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else if (in_op >= OP_RESET && in_op <= OP_SEARCH) begin
            n_cmd  = in_op;
            n_bit  = 3'd0;
            n_tick = 8'd0;
            if (in_op == OP_RESET) begin
                n_sticky = 1'b0;
                n_poll   = 8'd0;
                n_phase  = PH_RST;
            end else begin
                if (in_op == OP_WRITE) begin
                    shift_start = in_data;
                end else if (in_op != OP_READ) begin
                    shift_start = {7'd0, in_data[0]};
                end
                n_shift = shift_start;
                n_phase = slot_phase(in_op, 3'd0, shift_start);
            end
        end

        if (rd_end) begin
            if (r_cmd == OP_READ) begin
                n_shift = {rd_bit, r_shift[7:1]};
                if (r_bit == 3'd7) begin
                    n_res.read_value = n_sticky ? 8'd0 : n_shift;
                    fin = 1'b1;
                end else begin
                    n_bit   = r_bit + 3'd1;
                    n_phase = PH_WAIT_LOW;
                end
            end else if (r_cmd == OP_MATCH) begin
                n_res.matched = (rd_bit == r_shift[0]) && !n_sticky;
                fin = 1'b1;
            end else begin
                n_res.matched = !rd_to;
                fin = 1'b1;
            end
        end

        if (wr_end) begin
            if (r_cmd == OP_WRITE && r_bit == 3'd7) begin
                fin = 1'b1;
            end else begin
                n_bit   = r_bit + 3'd1;
                n_phase = PH_WAIT_LOW;
            end
        end

        if (fin) begin
            n_res.done_res      = 1'b1;
            n_res.finished_kind = r_cmd;
            n_phase             = PH_IDLE;
            n_cmd               = OP_TICK;
        end

        n_res.error    = n_sticky;
        n_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cmd     <= OP_TICK;
            r_tick    <= 8'd0;
            r_poll    <= 8'd0;
            r_bit     <= 3'd0;
            r_shift   <= 8'd0;
            r_sampled <= 1'b0;
            r_sticky  <= 1'b0;
        end else if (s_acc) begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_tick    <= n_tick;
            r_poll    <= n_poll;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_sampled <= n_sampled;
            r_sticky  <= n_sticky;
        end
    end

    // output buffer: result register backed by a skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (s_acc) begin
            if (!r_m_valid || m_acc) begin
                r_m_valid <= 1'b1;
            end else begin
                r_sk_valid <= 1'b1;
            end
        end else if (m_acc) begin
            r_m_valid  <= r_sk_valid;
            r_sk_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            if (!r_m_valid || m_acc) begin
                r_m_data <= n_res;
            end else begin
                r_sk_data <= n_res;
            end
        end else if (m_acc && r_sk_valid) begin
            r_m_data <= r_sk_data;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_data.finished_kind;
    assign o_m_tdata  = {2'b00, r_m_data.busy_res, r_m_data.error, r_m_data.matched,
                         r_m_data.read_value, r_m_data.reset_seen, r_m_data.done_res,
                         r_m_data.drive_low};

endmodule

/* sim/onewire_slave_bit_engine_checker.sv */
module onewire_slave_bit_engine_checker
    import owsbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [0] line, [8:1] data, [15:9] zero
    input  logic [2:0]  i_s_tuser,   // [2:0] op
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [0] drive_low, [1] done_res, [2] reset_seen,
                                     // [10:3] read_value, [11] matched, [12] error,
                                     // [13] busy_res, [15:14] zero
    input  logic [2:0]  i_m_tuser,   // [2:0] finished_kind
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_engine_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg_array timing;
    t_phase     phase;
    logic [2:0] cmd;
    logic [7:0] tick_cnt;
    logic [7:0] poll_cnt;
    logic [2:0] bit_idx;
    logic [7:0] shift_byte;
    logic       sampled;
    logic       sticky_err;
    t_result    res;                    // result of the item being stepped
    t_result    expected_results [$];
    int         fails = 0;
    int         result_no = 0;

    task automatic finish_cmd();
        res.done_res      = 1'b1;
        res.finished_kind = cmd;
        phase             = PH_IDLE;
        cmd               = OP_TICK;
    endtask

    task automatic start_slot();
        logic w;
        tick_cnt = '0;
        if (cmd == OP_READ || cmd == OP_MATCH || (cmd == OP_SEARCH && bit_idx >= 3'd2)) begin
            phase = PH_RD_SAMPLE;
        end else begin
            // search: true bit first, then its complement
            if (cmd == OP_WRITE)
                w = shift_byte[bit_idx];
            else
                w = shift_byte[0] ^ (bit_idx != 3'd0);
            phase = w ? PH_WR_ONE : PH_WR_LOW;
        end
    endtask

    task automatic end_read_slot(input logic b, input logic timed_out);
        if (cmd == OP_READ) begin
            shift_byte = {b, shift_byte[7:1]};
            if (bit_idx == 3'd7) begin
                res.read_value = sticky_err ? 8'h00 : shift_byte;
                finish_cmd();
            end else begin
                bit_idx++;
                phase = PH_WAIT_LOW;
            end
        end else if (cmd == OP_MATCH) begin
            res.matched = (b == shift_byte[0]) && !sticky_err;
            finish_cmd();
        end else begin
            res.matched = !timed_out;
            finish_cmd();
        end
    endtask

    task automatic end_write_slot();
        if (cmd == OP_WRITE && bit_idx == 3'd7) begin
            finish_cmd();
        end else begin
            bit_idx++;
            phase = PH_WAIT_LOW;
        end
    endtask

    task automatic step_bit_engine(input logic [2:0] op, input logic line,
                                   input logic [7:0] data);
        res = '0;
        if (phase != PH_IDLE) begin
            // busy: any op is just a tick
            case (phase)
                PH_RST: begin
                    tick_cnt++;
                    if (tick_cnt >= POLL_TICKS) begin
                        tick_cnt = '0;
                        if (!line)
                            poll_cnt++;
                        if (line || poll_cnt >= timing[REG_MAXP]) begin
                            res.reset_seen = poll_cnt >= timing[REG_MINP];
                            finish_cmd();
                        end
                    end
                end
                PH_RD_SAMPLE: begin
                    tick_cnt++;
                    if (tick_cnt >= timing[REG_SAMPLE]) begin
                        sampled  = line;
                        tick_cnt = '0;
                        if (cmd == OP_SEARCH && sampled != shift_byte[0]) begin
                            res.matched = 1'b0;
                            finish_cmd();
                        end else begin
                            phase = PH_RD_TAIL;
                        end
                    end
                end
                PH_RD_TAIL: begin
                    tick_cnt++;
                    if (tick_cnt >= timing[REG_TAIL]) begin
                        tick_cnt = '0;
                        if (line)
                            end_read_slot(sampled, 1'b0);
                        else
                            phase = PH_RD_HOLD;
                    end
                end
                PH_RD_HOLD: begin
                    if (line) begin
                        end_read_slot(sampled, 1'b0);
                    end else begin
                        tick_cnt++;
                        if (tick_cnt >= timing[REG_TIMEOUT]) begin
                            sticky_err = 1'b1;
                            end_read_slot(1'b0, 1'b1);
                        end
                    end
                end
                PH_WR_ONE: begin
                    tick_cnt++;
                    if (tick_cnt >= timing[REG_ONE])
                        end_write_slot();
                end
                PH_WR_LOW: begin
                    res.drive_low = 1'b1;
                    tick_cnt++;
                    if (tick_cnt >= timing[REG_ZLOW]) begin
                        tick_cnt = '0;
                        if (timing[REG_ZREL] == 8'd0)
                            end_write_slot();
                        else
                            phase = PH_WR_REL;
                    end
                end
                PH_WR_REL: begin
                    tick_cnt++;
                    if (tick_cnt >= timing[REG_ZREL])
                        end_write_slot();
                end
                PH_WAIT_LOW: begin
                    if (!line)
                        start_slot();
                end
                default: begin
                    phase = PH_IDLE;
                end
            endcase
        end else if (op >= OP_RESET && op <= OP_SEARCH) begin
            cmd      = op;
            bit_idx  = '0;
            tick_cnt = '0;
            if (op == OP_RESET) begin
                sticky_err = 1'b0;
                poll_cnt   = '0;
                phase      = PH_RST;
            end else begin
                if (op == OP_READ)
                    shift_byte = '0;
                else if (op == OP_WRITE)
                    shift_byte = data;
                else
                    shift_byte = {7'd0, data[0]};
                start_slot();
            end
        end
        res.error    = sticky_err;
        res.busy_res = phase != PH_IDLE;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            timing     = CFG_RESET;
            phase      = PH_IDLE;
            cmd        = OP_TICK;
            tick_cnt   = '0;
            poll_cnt   = '0;
            bit_idx    = '0;
            shift_byte = '0;
            sampled    = 1'b0;
            sticky_err = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we)
                timing[i_cfg_index] = i_cfg_data;
            // the result leaving now belongs to an earlier item, so check before queueing
            if (i_m_tvalid && i_m_tready) begin
                result_no++;
                got.drive_low     = i_m_tdata[0];
                got.done_res      = i_m_tdata[1];
                got.finished_kind = i_m_tuser;
                got.reset_seen    = i_m_tdata[2];
                got.read_value    = i_m_tdata[10:3];
                got.matched       = i_m_tdata[11];
                got.error         = i_m_tdata[12];
                got.busy_res      = i_m_tdata[13];
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("result %0d arrived with nothing expected", result_no);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display({"result %0d mismatch (exp/act): drive %b/%b done %b/%b ",
                                      "kind %0d/%0d reset %b/%b value %h/%h match %b/%b ",
                                      "error %b/%b busy %b/%b"},
                                     result_no, want.drive_low, got.drive_low,
                                     want.done_res, got.done_res,
                                     want.finished_kind, got.finished_kind,
                                     want.reset_seen, got.reset_seen,
                                     want.read_value, got.read_value,
                                     want.matched, got.matched, want.error, got.error,
                                     want.busy_res, got.busy_res);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                step_bit_engine(i_s_tuser, i_s_tdata[0], i_s_tdata[8:1]);
                expected_results.push_back(res);
            end
        end
        o_fail_count  <= fails;
        o_pending     <= expected_results.size();
        o_engine_busy <= phase != PH_IDLE;
    end

endmodule

/* sim/onewire_slave_bit_engine_test.sv */
module onewire_slave_bit_engine_test;
    timeunit 1ns;
    timeprecision 1ps;
    import owsbe_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    // ops the block does not define
    localparam logic [2:0] OP_UNDEF_6 = 3'd6;
    localparam logic [2:0] OP_UNDEF_7 = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_SAMPLE;
    logic [7:0]  cfg_data = '0;

    int          fail_count;
    int          pending;
    logic        engine_busy;

    t_cfg_array  cfg;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int          rx_wait = 0;
    int          cycles = 0;
    logic        bus_level = 1'b1;
    int          run_left = 0;

    onewire_slave_bit_engine u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    onewire_slave_bit_engine_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_engine_busy (engine_busy)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("onewire_slave_bit_engine_test failed");
            $finish;
        end
    end

    // receiver: a random stall after each result, with calm stretches
    always @(posedge clk) begin
        if (m_tvalid && m_tready)
            rx_wait = rx_calm ? 0 : $urandom_range(0, 5);
        else if (rx_wait != 0)
            rx_wait--;
        if ($urandom_range(0, 99) == 0)
            rx_calm = !rx_calm;
        m_tready <= rst_n && rx_wait == 0;
    end

    // bus level as the master would leave it: alternating runs, mostly short
    function automatic logic next_line();
        int pick;
        if (run_left == 0) begin
            bus_level = !bus_level;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                run_left = $urandom_range(1, 6);
            else if (pick < 95)
                run_left = $urandom_range(7, 60);
            else
                run_left = $urandom_range(61, 300);
        end
        run_left--;
        return bus_level;
    endfunction

    task automatic write_timing();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= cfg[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // leaves tvalid high on return; the caller either sends again or lowers it
    task automatic send_item(input logic [2:0] op, input logic line, input logic [7:0] data);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, data, line};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if ($urandom_range(0, 63) == 0)
            tx_calm = !tx_calm;
    endtask

    // engine_busy lags one item, so at least one tick goes out before it is trusted
    task automatic drain(input logic [7:0] pattern, input bit patterned);
        int n;
        n = 0;
        do begin
            send_item(OP_TICK, patterned ? pattern[n % 8] : next_line(),
                      8'($urandom_range(0, 255)));
            n++;
        end while (engine_busy);
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_cmd(input logic [2:0] op, input logic [7:0] data,
                                input logic [7:0] pattern);
        send_item(op, pattern[0], data);
        drain(pattern, 1'b1);
    endtask

    task automatic random_traffic(input int count);
        int         sent;
        logic [2:0] op;
        sent = 0;
        while (sent < count) begin
            if (!engine_busy) begin
                if ($urandom_range(0, 3) != 0)
                    op = 3'($urandom_range(OP_RESET, OP_SEARCH));
                else
                    op = 3'($urandom_range(0, 7));
            end else begin
                op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : OP_TICK;
            end
            if (engine_busy || (op >= OP_RESET && op <= OP_SEARCH))
                sent++;
            send_item(op, next_line(), 8'($urandom_range(0, 255)));
        end
        drain(8'h00, 1'b0);
    endtask

    initial begin
        int n_items;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // shortest timing, with the zero-length tail and release counts
        cfg = '{8'd1, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0, 8'd1, 8'd1};
        write_timing();
        send_item(OP_TICK, 1'b1, 8'hFF);
        send_item(OP_UNDEF_6, 1'b0, 8'h00);
        send_item(OP_UNDEF_7, 1'b1, 8'hFF);
        s_tvalid <= 1'b0;
        @(posedge clk);
        directed_cmd(OP_RESET, 8'h00, 8'h00);     // held low: reset seen
        directed_cmd(OP_RESET, 8'hFF, 8'hFF);     // released at first poll
        directed_cmd(OP_READ, 8'h00, 8'h00);      // stuck low: release timeout
        directed_cmd(OP_MATCH, 8'h01, 8'h55);     // sticky error forces no match
        directed_cmd(OP_RESET, 8'h00, 8'h00);     // clears the error
        directed_cmd(OP_READ, 8'hFF, 8'h36);
        directed_cmd(OP_WRITE, 8'h00, 8'h66);
        directed_cmd(OP_WRITE, 8'hFF, 8'h66);
        directed_cmd(OP_WRITE, 8'hA5, 8'h66);
        directed_cmd(OP_MATCH, 8'h00, 8'h0F);
        directed_cmd(OP_MATCH, 8'hFF, 8'h0F);
        directed_cmd(OP_SEARCH, 8'h00, 8'h33);
        directed_cmd(OP_SEARCH, 8'h01, 8'h33);
        directed_cmd(OP_SEARCH, 8'h01, 8'h00);    // master bit differs: early finish
        directed_cmd(OP_SEARCH, 8'h00, 8'h00);    // bit agrees, release times out
        send_item(OP_READ, 1'b0, 8'h00);
        send_item(OP_WRITE, 1'b0, 8'hFF);         // ignored while busy
        drain(8'h5A, 1'b1);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    cfg = CFG_RESET;
                    n_items = 60;
                end
                1: begin
                    cfg = '{8'd1, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0, 8'd1, 8'd1};
                    n_items = 100;
                end
                6: begin
                    // full-range timeout and poll limits; these end early on the line
                    cfg = '{8'd3, 8'd2, 8'd255, 8'd3, 8'd3, 8'd2, 8'd255, 8'd255};
                    n_items = 15;
                end
                default: begin
                    cfg[REG_SAMPLE]  = 8'($urandom_range(1, 6));
                    cfg[REG_TAIL]    = 8'($urandom_range(0, 6));
                    cfg[REG_TIMEOUT] = 8'($urandom_range(1, 8));
                    cfg[REG_ONE]     = 8'($urandom_range(1, 6));
                    cfg[REG_ZLOW]    = 8'($urandom_range(1, 6));
                    cfg[REG_ZREL]    = 8'($urandom_range(0, 6));
                    cfg[REG_MINP]    = 8'($urandom_range(1, 4));
                    cfg[REG_MAXP]    = 8'($urandom_range(1, 6));
                    n_items = 100;
                end
            endcase
            while (pending != 0)
                @(posedge clk);
            write_timing();
            random_traffic(n_items);
        end

        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("onewire_slave_bit_engine_test passed");
        else
            $display("onewire_slave_bit_engine_test failed");
        $finish;
    end

endmodule

/* onewire_slave_bit_engine.f */
sv/owsbe_pkg.sv
sv/onewire_slave_bit_engine.sv
sim/onewire_slave_bit_engine_checker.sv
sim/onewire_slave_bit_engine_test.sv
